FILE: rtl/assert_macros.svh
// assertion helpers, sampled on clk with synchronous reset active low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every cycle out of reset
`define HFA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hfa_pkg.sv
package hfa_pkg;

  localparam int AMOUNT_W    = 16;
  localparam int HOLE_W      = 4;
  localparam int POLICY_W    = 2;
  localparam int HOLES_CFG_W = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  typedef logic [POLICY_W-1:0] fit_policy_t;

  localparam fit_policy_t POL_FIRST = 2'd0;
  localparam fit_policy_t POL_BEST  = 2'd1;
  localparam fit_policy_t POL_WORST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLES_IN_USE = 1'd1;

  localparam logic [HOLES_CFG_W-1:0] HOLES_RESET = 5'd16;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // control from the sequencer to the candidate tracker
  typedef struct packed {
    logic        clear;
    logic        en;
    fit_policy_t policy;
  } pick_ctl_t;

endpackage

FILE: rtl/hfa_pick.sv
module hfa_pick import hfa_pkg::*; #(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pick_ctl_t            ctl,
  input  logic [SIZE_BITS-1:0] req_size,
  input  logic [SIZE_BITS-1:0] cand_size,
  input  logic [IDX_W-1:0]     cand_idx,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx,
  output logic [SIZE_BITS-1:0] pick_size
);

  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_idx_r;
  logic [SIZE_BITS-1:0] pick_size_r;
  logic                 fits;
  logic                 take;

  assign fits = (req_size <= cand_size);

  // lower index wins a tie, so only a strict improvement replaces the pick
  always_comb begin
    take = 1'b0;
    if (ctl.en && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (ctl.policy)
          POL_BEST:  take = (cand_size < pick_size_r);
          POL_WORST: take = (cand_size > pick_size_r);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && take) begin
      pick_idx_r  <= cand_idx;
      pick_size_r <= cand_size;
    end
  end

  assign found     = found_r;
  assign pick_idx  = pick_idx_r;
  assign pick_size = pick_size_r;

endmodule

FILE: rtl/hole_fit_allocator.sv
// channel   ports                                                  transfer when
// -------   -----------------------------------------------------  --------------------------
// input     in_kind, in_hole_index, in_amount                      start && !busy
// result    out_answers_request, out_granted, out_chosen_hole,     out_strobe (one cycle)
//           out_space_left
// config    cfg_we, cfg_index, cfg_wdata                           cfg_we
//
// a load writes the table in the cycle it is taken; its result strobes the next cycle
// and busy stays low, so another item may follow at once.
// a request scans n = min(holes_in_use, HOLE_COUNT) entries, one memory read per cycle,
// then drains the read, then writes back; busy stays high through the write-back, and the
// result is registered from the write-back state.
// with n = 0 the scan and drain are skipped and the request goes straight to write-back.
// reset is synchronous: table reads as zero through per-entry valid bits, no clearing pass.
// results cannot be stalled; each strobe lasts exactly one cycle.
`include "assert_macros.svh"

module hole_fit_allocator import hfa_pkg::*; #(
  parameter int HOLE_COUNT = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic [HOLE_W-1:0]      in_hole_index,
  input  logic [AMOUNT_W-1:0]    in_amount,
  output logic                   out_strobe,
  output logic                   out_answers_request,
  output logic                   out_granted,
  output logic [HOLE_W-1:0]      out_chosen_hole,
  output logic [AMOUNT_W-1:0]    out_space_left,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (HOLE_COUNT > 1) ? $clog2(HOLE_COUNT) : 1;
  localparam int CNT_W = $clog2(HOLE_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  fit_policy_t             policy_r;
  logic [HOLES_CFG_W-1:0]  holes_r;

  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]        lim_r, lim_nxt;
  logic [CNT_W-1:0]        lim_cfg;
  logic [SIZE_BITS-1:0]    amt_r;
  logic [SIZE_BITS-1:0]    in_amt;

  logic [SIZE_BITS-1:0]    mem [HOLE_COUNT];
  logic [HOLE_COUNT-1:0]   valid_r;
  logic [SIZE_BITS-1:0]    rd_data_r;
  logic                    rd_valid_r;
  logic                    cmp_en_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic [IDX_W-1:0]        rd_addr;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [SIZE_BITS-1:0]    mem_wdata;

  logic                    accept;
  logic                    load_go;
  logic                    load_in_range;
  logic                    req_go;

  pick_ctl_t               pick_ctl;
  logic                    found;
  logic [IDX_W-1:0]        pick_idx;
  logic [SIZE_BITS-1:0]    pick_size;
  logic [SIZE_BITS-1:0]    cand_size;
  logic [SIZE_BITS-1:0]    shrunk;

  logic                    out_strobe_r;
  logic                    out_req_r;
  logic                    out_granted_r;
  logic [HOLE_W-1:0]       out_hole_r;
  logic [AMOUNT_W-1:0]     out_left_r;

  assign busy          = (state_r != S_IDLE);
  assign accept        = start && (state_r == S_IDLE);
  assign load_go       = accept && (in_kind == KIND_LOAD);
  assign req_go        = accept && (in_kind == KIND_REQUEST);
  assign load_in_range = (32'(in_hole_index) < 32'(HOLE_COUNT));
  assign in_amt        = SIZE_BITS'(in_amount);

  // search length saturates at the table depth
  assign lim_cfg = (32'(holes_r) > 32'(HOLE_COUNT)) ? CNT_W'(HOLE_COUNT) : CNT_W'(holes_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      holes_r  <= HOLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:   policy_r <= cfg_wdata[POLICY_W-1:0];
        CFG_HOLES_IN_USE: holes_r  <= cfg_wdata[HOLES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    lim_nxt    = lim_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_go) begin
          lim_nxt    = lim_cfg;
          rd_idx_nxt = '0;
          state_nxt  = (lim_cfg == '0) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
        if (rd_idx_r == lim_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_idx_r <= '0;
      lim_r    <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      lim_r    <= lim_nxt;
      cmp_en_r <= (state_r == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      amt_r <= in_amt;
    end
  end

  // table memory: one write port, one registered read port
  assign rd_addr = rd_idx_r[IDX_W-1:0];
  assign shrunk  = pick_size - amt_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(in_hole_index);
    mem_wdata = in_amt;
    if (load_go && load_in_range) begin
      mem_we = 1'b1;
    end else if ((state_r == S_COMMIT) && found) begin
      mem_we    = 1'b1;
      mem_waddr = pick_idx;
      mem_wdata = shrunk;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[rd_addr];
    cmp_idx_r  <= rd_addr;
  end

  // never-written entries read as zero
  assign cand_size = rd_valid_r ? rd_data_r : '0;

  assign pick_ctl.clear  = req_go;
  assign pick_ctl.en     = cmp_en_r;
  assign pick_ctl.policy = policy_r;

  hfa_pick #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .req_size  (amt_r),
    .cand_size (cand_size),
    .cand_idx  (cmp_idx_r),
    .found     (found),
    .pick_idx  (pick_idx),
    .pick_size (pick_size)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= load_go || (state_r == S_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      out_req_r     <= 1'b0;
      out_granted_r <= 1'b0;
      out_hole_r    <= in_hole_index;
      out_left_r    <= load_in_range ? AMOUNT_W'(in_amt) : '0;
    end else if (state_r == S_COMMIT) begin
      out_req_r     <= 1'b1;
      out_granted_r <= found;
      out_hole_r    <= found ? HOLE_W'(pick_idx) : '0;
      out_left_r    <= found ? AMOUNT_W'(shrunk) : '0;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_answers_request = out_req_r;
  assign out_granted         = out_granted_r;
  assign out_chosen_hole     = out_hole_r;
  assign out_space_left      = out_left_r;

  `HFA_ASSERT_NEXT(a_req_goes_busy, req_go, busy, "request transfer did not raise busy")
  `HFA_ASSERT_NEXT(a_commit_strobes, (state_r == S_COMMIT),
                   (out_strobe && out_answers_request), "commit gave no request result")
  `HFA_ASSERT_ALWAYS(a_scan_in_range, ((state_r != S_SCAN) || (rd_idx_r < lim_r)),
                     "scan index ran past search length")
  `HFA_ASSERT_ALWAYS(a_grant_is_request, (!out_strobe || !out_granted || out_answers_request),
                     "grant flagged on a load result")

endmodule

FILE: tb/sv/tb_hole_fit_allocator.sv
module tb_hole_fit_allocator;
  import hfa_pkg::*;

  localparam int HOLES        = 16;
  localparam int DRAIN_PAD    = 24;
  localparam int STALL_LIMIT  = 600;

  // encoding the block treats as first fit
  localparam fit_policy_t POL_UNDEF = 2'd3;

  typedef struct packed {
    logic                answers_request;
    logic                granted;
    logic [HOLE_W-1:0]   chosen_hole;
    logic [AMOUNT_W-1:0] space_left;
  } alloc_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_kind;
  logic [HOLE_W-1:0]      in_hole_index;
  logic [AMOUNT_W-1:0]    in_amount;
  logic                   out_strobe;
  logic                   out_answers_request;
  logic                   out_granted;
  logic [HOLE_W-1:0]      out_chosen_hole;
  logic [AMOUNT_W-1:0]    out_space_left;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // testbench copy of the hole table and settings
  logic [AMOUNT_W-1:0]    hole_size [HOLES];
  fit_policy_t            cur_policy;
  logic [HOLES_CFG_W-1:0] cur_holes;

  alloc_result_t expected_results[$];

  int  mismatch_count = 0;
  int  load_count     = 0;
  int  request_count  = 0;
  int  granted_count  = 0;
  int  refused_count  = 0;
  int  settings_count = 0;
  int  stall_cycles   = 0;
  bit  no_gaps        = 0;

  hole_fit_allocator #(
    .HOLE_COUNT (HOLES),
    .SIZE_BITS  (AMOUNT_W)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_hole_index       (in_hole_index),
    .in_amount           (in_amount),
    .out_strobe          (out_strobe),
    .out_answers_request (out_answers_request),
    .out_granted         (out_granted),
    .out_chosen_hole     (out_chosen_hole),
    .out_space_left      (out_space_left),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int search_length();
    return (cur_holes > HOLES) ? HOLES : int'(cur_holes);
  endfunction

  // apply one item to the table copy and return the result it should give
  function automatic alloc_result_t predict_alloc(input logic kind,
                                                  input logic [HOLE_W-1:0] idx,
                                                  input logic [AMOUNT_W-1:0] amt);
    alloc_result_t r;
    int            n;
    int            pick;
    bit            found;
    r = '0;
    if (kind == KIND_LOAD) begin
      hole_size[idx] = amt;
      r.chosen_hole  = idx;
      r.space_left   = amt;
      return r;
    end
    r.answers_request = 1'b1;
    n     = search_length();
    pick  = 0;
    found = 0;
    for (int j = 0; j < n; j++) begin
      if (amt > hole_size[j]) continue;
      if (!found) begin
        found = 1;
        pick  = j;
        if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
      end else if (cur_policy == POL_BEST) begin
        if (hole_size[j] < hole_size[pick]) pick = j;
      end else if (cur_policy == POL_WORST) begin
        if (hole_size[j] > hole_size[pick]) pick = j;
      end
    end
    if (!found) return r;
    hole_size[pick] = hole_size[pick] - amt;
    r.granted       = 1'b1;
    r.chosen_hole   = pick[HOLE_W-1:0];
    r.space_left    = hole_size[pick];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_item(input logic kind, input logic [HOLE_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt);
    int gap;
    bit taken;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         = 1'b1;
    in_kind       = kind;
    in_hole_index = idx;
    in_amount     = amt;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1;
    end
    expected_results.push_back(predict_alloc(kind, idx, amt));
    if (kind == KIND_LOAD) load_count++;
    else request_count++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FIT_POLICY) cur_policy = data[POLICY_W-1:0];
    else cur_holes = data[HOLES_CFG_W-1:0];
  endtask

  // only called with the block idle
  task automatic set_config(input fit_policy_t policy, input logic [HOLES_CFG_W-1:0] holes);
    wait_drain();
    write_cfg(CFG_FIT_POLICY, CFG_DATA_W'(policy));
    write_cfg(CFG_HOLES_IN_USE, CFG_DATA_W'(holes));
    settings_count++;
  endtask

  task automatic run_random_items(input int count);
    int                  r;
    int                  n;
    logic [HOLE_W-1:0]   idx;
    logic [HOLE_W-1:0]   tie_hole;
    logic [AMOUNT_W-1:0] amt;
    logic [AMOUNT_W-1:0] off;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(3) == 0);
      n        = search_length();
      off      = AMOUNT_W'($urandom_range(4));
      tie_hole = HOLE_W'($urandom_range(15));
      r        = $urandom_range(99);
      if (r < 35) begin
        idx = HOLE_W'(($urandom_range(1) && n > 0) ? $urandom_range(n - 1)
                                                   : $urandom_range(15));
        r = $urandom_range(99);
        if (r < 25) amt = AMOUNT_W'($urandom_range(63));
        else if (r < 40) amt = hole_size[tie_hole];  // provoke ties
        else if (r < 50) amt = $urandom_range(1) ? '1 : '0;
        else amt = AMOUNT_W'($urandom_range(65535));
        send_item(KIND_LOAD, idx, amt);
      end else begin
        idx = HOLE_W'($urandom_range(15));
        r = $urandom_range(99);
        if (r < 30) amt = hole_size[tie_hole];
        else if (r < 60) amt = AMOUNT_W'($urandom_range(31));
        else if (r < 75) amt = hole_size[tie_hole] + AMOUNT_W'(1) - off;
        else amt = AMOUNT_W'($urandom_range(65535));
        send_item(KIND_REQUEST, idx, amt);
      end
    end
    no_gaps = 0;
  endtask

  task automatic test_directed();
    // zero-size request fits an empty hole; anything larger is refused
    send_item(KIND_REQUEST, 4'd0, 16'd0);
    send_item(KIND_REQUEST, 4'hF, 16'd1);
    send_item(KIND_LOAD, 4'd0, 16'hFFFF);
    send_item(KIND_LOAD, 4'hF, 16'hFFFF);
    send_item(KIND_LOAD, 4'd3, 16'd50);
    send_item(KIND_LOAD, 4'd5, 16'd100);
    send_item(KIND_LOAD, 4'd9, 16'd100);
    send_item(KIND_REQUEST, 4'd0, 16'hFFFF);
    send_item(KIND_REQUEST, 4'd0, 16'd60);
    set_config(POL_BEST, HOLES_RESET);
    send_item(KIND_REQUEST, 4'd0, 16'd45);
    send_item(KIND_REQUEST, 4'd0, 16'd40);
    send_item(KIND_LOAD, 4'd3, 16'd55);
    send_item(KIND_REQUEST, 4'd0, 16'd10);
    set_config(POL_WORST, HOLES_RESET);
    send_item(KIND_REQUEST, 4'd0, 16'd1);
    send_item(KIND_LOAD, 4'd0, 16'hFFFE);
    send_item(KIND_REQUEST, 4'd0, 16'd2);
    set_config(POL_UNDEF, HOLES_RESET);
    send_item(KIND_REQUEST, 4'd0, 16'd5);
    set_config(POL_FIRST, 5'd0);
    send_item(KIND_REQUEST, 4'd0, 16'd0);
    set_config(POL_WORST, 5'd31);
    send_item(KIND_REQUEST, 4'd0, 16'hFFFF);
    send_item(KIND_REQUEST, 4'd0, 16'hFFF0);
    set_config(POL_BEST, 5'd1);
    send_item(KIND_REQUEST, 4'd0, 16'd0);
  endtask

  task automatic test_first_fit();
    set_config(POL_FIRST, HOLES_RESET);
    run_random_items(80);
    set_config(POL_UNDEF, 5'd16);
    run_random_items(40);
  endtask

  task automatic test_best_fit();
    set_config(POL_BEST, HOLES_RESET);
    run_random_items(90);
    set_config(POL_BEST, 5'($urandom_range(15, 2)));
    run_random_items(50);
  endtask

  task automatic test_worst_fit();
    set_config(POL_WORST, HOLES_RESET);
    run_random_items(90);
  endtask

  task automatic test_search_length();
    set_config(POL_BEST, 5'd1);
    run_random_items(40);
    set_config(POL_WORST, 5'd0);
    run_random_items(30);
    set_config(POL_FIRST, 5'd31);
    run_random_items(40);
    set_config(POL_WORST, 5'd17);
    run_random_items(40);
  endtask

  task automatic test_mixed_settings();
    for (int k = 0; k < 3; k++) begin
      set_config(fit_policy_t'($urandom_range(3)), 5'($urandom_range(31)));
      run_random_items(35);
    end
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_answers_request !== want.answers_request) begin
          $error("answers_request: expected %0d, got %0d", want.answers_request,
                 out_answers_request);
          mismatch_count++;
        end
        if (out_granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, out_granted);
          mismatch_count++;
        end
        if (out_chosen_hole !== want.chosen_hole) begin
          $error("chosen_hole: expected %0d, got %0d", want.chosen_hole, out_chosen_hole);
          mismatch_count++;
        end
        if (out_space_left !== want.space_left) begin
          $error("space_left: expected %0d, got %0d", want.space_left, out_space_left);
          mismatch_count++;
        end
        if (want.answers_request) begin
          if (want.granted) granted_count++;
          else refused_count++;
        end
      end
    end
  end

  // ends the run if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = KIND_LOAD;
    in_hole_index = '0;
    in_amount     = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FIT_POLICY;
    cfg_wdata     = '0;
    cur_policy    = POL_FIRST;
    cur_holes     = HOLES_RESET;
    for (int j = 0; j < HOLES; j++) hole_size[j] = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_search_length();
    test_mixed_settings();
    wait_drain();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatch_count++;
    end
    $display("covered %0d loads and %0d requests under %0d settings changes",
             load_count, request_count, settings_count);
    $display("requests granted %0d, refused %0d, field mismatches %0d",
             granted_count, refused_count, mismatch_count);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hfa_pkg.sv
rtl/hfa_pick.sv
rtl/hole_fit_allocator.sv
tb/sv/tb_hole_fit_allocator.sv
